/* hw/rtl/dwa_pkg.sv */
// Package: field widths, operation codes and helpers for the DFA word acceptor.
`timescale 1ns / 1ps

package dwa_pkg;

	localparam int unsigned NUM_STATES_DEF    = 16;
	localparam int unsigned ALPHABET_SIZE_DEF = 256;

	localparam int unsigned OP_W     = 2;
	localparam int unsigned STATE_FW = 4;
	localparam int unsigned LETTER_W = 8;

	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned OUT_DATA_W = 8;

	typedef enum logic [OP_W-1:0] {
		OP_SET_TRANS = 2'd0,
		OP_SET_ACCEPT = 2'd1,
		OP_BEGIN_WORD = 2'd2,
		OP_FEED_LETTER = 2'd3
	} op_t;

	typedef struct packed {
		op_t                 operation;
		logic [STATE_FW-1:0] from_state;
		logic [LETTER_W-1:0] letter;
		logic [STATE_FW-1:0] target_state;
		logic                accept_value;
	} item_t;

	// start state reduced modulo the state count (for a count of two or more); at most eight subtract steps on 4 bits
	function automatic logic [STATE_FW-1:0] state_mod(input logic [STATE_FW-1:0] v,
			input int unsigned n);
		logic [STATE_FW-1:0] r;
		r = v;
		for (int i = 0; i < 8; i++) begin
			if (32'(r) >= n)
				r = r - STATE_FW'(n);
		end
		return r;
	endfunction

endpackage

/* hw/rtl/dwa_table_ram.sv */
// Transition table memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module dwa_table_ram import dwa_pkg::*; #(
	parameter int unsigned DEPTH = NUM_STATES_DEF * ALPHABET_SIZE_DEF,
	parameter int unsigned AW    = 12,
	parameter int unsigned DW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/dwa_clear_seq.sv */
// Post-reset sweep that invalidates every transition table entry.
`timescale 1ns / 1ps

module dwa_clear_seq import dwa_pkg::*; #(
	parameter int unsigned DEPTH = NUM_STATES_DEF * ALPHABET_SIZE_DEF,
	parameter int unsigned AW    = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	output logic          busy,
	output logic [AW-1:0] addr
);

	logic [AW-1:0] cnt_q;
	logic          busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (cnt_q == AW'(DEPTH - 1))
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q + 1'b1;
		end
	end

	assign busy = busy_q;
	assign addr = cnt_q;

endmodule

/* hw/rtl/dfa_word_acceptor.sv */
// Top level of the programmable DFA word acceptor.
//
//  group   dir  fields (tdata / tuser, lsb first)
//  s_axis  in   tuser: operation[1:0]; tdata: from_state[3:0], letter[11:4],
//               target_state[15:12], accept_value[16], zero[23:17]
//  m_axis  out  tdata: accepted[0], dead[1], current_state[5:2], zero[7:6]
//
// Each item is taken in ST_IDLE, where the transfer issues the table read, then ST_EXEC
// applies the item and loads the output register from the registered table read data.
// No new item is taken until ST_EXEC is left. After reset every table entry is swept
// invalid with s_axis_tready low. A held result stalls ST_EXEC and so also s_axis_tready.
`timescale 1ns / 1ps

module dfa_word_acceptor import dwa_pkg::*; #(
	parameter int unsigned NUM_STATES    = NUM_STATES_DEF,
	parameter int unsigned ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // from_state, letter, target_state, accept_value
	input  logic [OP_W-1:0]       s_axis_tuser,  // operation
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata   // accepted, dead, current_state
);

	localparam int unsigned SW    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
	localparam int unsigned LW    = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
	localparam int unsigned AW    = SW + LW;
	localparam int unsigned DEPTH = NUM_STATES << LW;
	localparam int unsigned TW    = SW + 1;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} fsm_t;

	fsm_t                  state_q;
	item_t                 item_s1;
	item_t                 in_item;
	logic [SW-1:0]         present_q;
	logic                  dead_q;
	logic [NUM_STATES-1:0] acc_flags_q;
	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	logic          clr_busy;
	logic [AW-1:0] clr_addr;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [TW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [TW-1:0] ram_rdata;

	logic                  in_xfer;
	logic                  exec_go;
	logic                  src_ok;
	logic                  dst_ok;
	logic                  sym_ok;
	logic [SW-1:0]         src_idx;
	logic [SW-1:0]         present_d;
	logic                  dead_d;
	logic [NUM_STATES-1:0] acc_flags_d;
	logic                  accepted_d;
	logic                  trans_we;

	assign in_item.operation    = op_t'(s_axis_tuser);
	assign in_item.from_state   = s_axis_tdata[3:0];
	assign in_item.letter       = s_axis_tdata[11:4];
	assign in_item.target_state = s_axis_tdata[15:12];
	assign in_item.accept_value = s_axis_tdata[16];

	assign s_axis_tready = (state_q == ST_IDLE) && !clr_busy;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign exec_go       = (state_q == ST_EXEC) && (!m_valid_q || m_axis_tready);

	dwa_clear_seq #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_clear (
		.clk   (clk),
		.arst_n(arst_n),
		.busy  (clr_busy),
		.addr  (clr_addr)
	);

	assign ram_re    = in_xfer;
	assign ram_raddr = {present_q, LW'(in_item.letter)};

	assign src_ok  = 32'(item_s1.from_state) < NUM_STATES;
	assign dst_ok  = 32'(item_s1.target_state) < NUM_STATES;
	assign sym_ok  = 32'(item_s1.letter) < ALPHABET_SIZE;
	assign src_idx = SW'(item_s1.from_state);

	assign trans_we  = exec_go && (item_s1.operation == OP_SET_TRANS) && src_ok && dst_ok
		&& sym_ok;
	assign ram_we    = clr_busy || trans_we;
	assign ram_waddr = clr_busy ? clr_addr : {src_idx, LW'(item_s1.letter)};
	assign ram_wdata = clr_busy ? '0 : {1'b1, SW'(item_s1.target_state)};

	dwa_table_ram #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.DW   (TW)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		present_d   = present_q;
		dead_d      = dead_q;
		acc_flags_d = acc_flags_q;
		case (item_s1.operation)
			OP_SET_TRANS: begin
			end
			OP_SET_ACCEPT: begin
				if (src_ok)
					acc_flags_d[src_idx] = item_s1.accept_value;
			end
			OP_BEGIN_WORD: begin
				present_d = SW'(state_mod(item_s1.from_state, NUM_STATES));
				dead_d    = 1'b0;
			end
			OP_FEED_LETTER: begin
				if (!dead_q) begin
					if (sym_ok && ram_rdata[TW-1])
						present_d = ram_rdata[SW-1:0];
					else
						dead_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
		accepted_d = !dead_d && acc_flags_d[present_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			present_q   <= '0;
			dead_q      <= 1'b0;
			acc_flags_q <= '0;
			m_valid_q   <= 1'b0;
			m_data_q    <= '0;
		end else begin
			if (m_valid_q && m_axis_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_xfer)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (exec_go) begin
						state_q     <= ST_IDLE;
						present_q   <= present_d;
						dead_q      <= dead_d;
						acc_flags_q <= acc_flags_d;
						m_valid_q   <= 1'b1;
						m_data_q    <= {2'b00, 4'(present_d), dead_d, accepted_d};
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer)
			item_s1 <= in_item;
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

/* dv/dfa_word_acceptor_test.sv */
// Testbench for dfa_word_acceptor: directed table plus random stream against a behavioral model.
`timescale 1ns / 1ps

module dfa_word_acceptor_test;
	import dwa_pkg::*;

	localparam int unsigned N_ST      = NUM_STATES_DEF;
	localparam int unsigned N_SYM     = ALPHABET_SIZE_DEF;
	localparam int          RAND_PER_PHASE = 470;
	localparam int          HOLD_CYCLES    = 60;
	localparam longint      LIMIT_NS       = 5_000_000;

	typedef struct packed {
		logic [STATE_FW-1:0] current_state;
		logic                dead;
		logic                accepted;
	} word_status_t;

	typedef struct {
		item_t        it;
		bit           typed;
		word_status_t want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [OP_W-1:0]       s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	dfa_word_acceptor DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// behavioral automaton
	bit                  trans_valid [N_ST][N_SYM];
	logic [STATE_FW-1:0] trans_next  [N_ST][N_SYM];
	logic [N_ST-1:0]     accept_mask;
	logic [STATE_FW-1:0] cur_state;
	bit                  is_dead;

	word_status_t pending_status[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_armed     = 1'b0;

	int errors          = 0;
	int results_checked = 0;
	int accepted_seen   = 0;
	int items_sent      = 0;
	int words_begun     = 0;
	int letters_taken   = 0;
	int words_killed    = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void clear_automaton();
		foreach (trans_valid[s, c]) begin
			trans_valid[s][c] = 1'b0;
			trans_next[s][c]  = '0;
		end
		accept_mask = '0;
		cur_state   = '0;
		is_dead     = 1'b0;
	endfunction

	function automatic word_status_t step_automaton(input item_t it);
		word_status_t r;
		case (it.operation)
			OP_SET_TRANS: begin
				trans_valid[it.from_state][it.letter] = 1'b1;
				trans_next[it.from_state][it.letter]  = it.target_state;
			end
			OP_SET_ACCEPT: begin
				accept_mask[it.from_state] = it.accept_value;
			end
			OP_BEGIN_WORD: begin
				cur_state = it.from_state;
				is_dead   = 1'b0;
				words_begun++;
			end
			OP_FEED_LETTER: begin
				if (!is_dead) begin
					if (trans_valid[cur_state][it.letter]) begin
						cur_state = trans_next[cur_state][it.letter];
						letters_taken++;
					end else begin
						is_dead = 1'b1;
						words_killed++;
					end
				end
			end
			default: begin
			end
		endcase
		r.current_state = cur_state;
		r.dead          = is_dead;
		r.accepted      = !is_dead && accept_mask[cur_state];
		return r;
	endfunction

	function automatic item_t mk(input op_t op, input int from, input int sym, input int to,
			input bit av);
		item_t it;
		it.operation    = op;
		it.from_state   = from[STATE_FW-1:0];
		it.letter       = sym[LETTER_W-1:0];
		it.target_state = to[STATE_FW-1:0];
		it.accept_value = av;
		return it;
	endfunction

	function automatic word_status_t ws(input int st, input bit dd, input bit ac);
		word_status_t w;
		w.current_state = st[STATE_FW-1:0];
		w.dead          = dd;
		w.accepted      = ac;
		return w;
	endfunction

	task automatic offer(input item_t it, input bit typed, input word_status_t want);
		word_status_t pred;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'b0, it.accept_value, it.target_state, it.letter, it.from_state};
		s_axis_tuser  <= it.operation;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		pred = step_automaton(it);
		pending_status.push_back(typed ? want : pred);
		items_sent++;
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_armed) begin
				hold_left  = HOLD_CYCLES;
				hold_armed = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		word_status_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = word_status_t'(m_axis_tdata[5:0]);
			if (pending_status.size() == 0) begin
				errors++;
				$display("%0t: unexpected result accepted=%0d dead=%0d state=%0d", $time,
					got.accepted, got.dead, got.current_state);
			end else begin
				want = pending_status.pop_front();
				results_checked++;
				if (got.accepted) accepted_seen++;
				if (got !== want) begin
					errors++;
					$display("%0t: expected acc=%0d dead=%0d st=%0d, got acc=%0d dead=%0d st=%0d",
						$time, want.accepted, want.dead, want.current_state,
						got.accepted, got.dead, got.current_state);
				end
			end
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("Timeout with %0d results outstanding", pending_status.size());
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		dir_row_t    dir_rows[$];
		logic [7:0]  pool[8];
		item_t       it;
		int          r;

		clear_automaton();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, dead words, extreme states and letters, mid-word table writes
		dir_rows.push_back('{mk(OP_BEGIN_WORD,   0, 8'h00,  0, 0), 1'b1, ws(0, 0, 0)});
		dir_rows.push_back('{mk(OP_FEED_LETTER,  0, 8'h00,  0, 0), 1'b1, ws(0, 1, 0)});
		dir_rows.push_back('{mk(OP_FEED_LETTER, 15, 8'hFF, 15, 1), 1'b1, ws(0, 1, 0)});
		dir_rows.push_back('{mk(OP_SET_ACCEPT,   0, 8'h00,  0, 1), 1'b1, ws(0, 1, 0)});
		dir_rows.push_back('{mk(OP_BEGIN_WORD,   0, 8'hFF, 15, 1), 1'b1, ws(0, 0, 1)});
		dir_rows.push_back('{mk(OP_BEGIN_WORD,  15, 8'h00,  0, 0), 1'b1, ws(15, 0, 0)});
		dir_rows.push_back('{mk(OP_SET_TRANS,   15, 8'hFF,  0, 0), 1'b1, ws(15, 0, 0)});
		dir_rows.push_back('{mk(OP_SET_ACCEPT,  15, 8'h00,  0, 1), 1'b1, ws(15, 0, 1)});
		dir_rows.push_back('{mk(OP_FEED_LETTER,  0, 8'hFF,  0, 0), 1'b1, ws(0, 0, 1)});
		dir_rows.push_back('{mk(OP_SET_TRANS,    0, 8'h00, 15, 1), 1'b0, ws(0, 0, 0)});
		dir_rows.push_back('{mk(OP_FEED_LETTER,  7, 8'h00,  3, 1), 1'b0, ws(0, 0, 0)});
		dir_rows.push_back('{mk(OP_SET_ACCEPT,  15, 8'hFF, 15, 0), 1'b0, ws(0, 0, 0)});
		dir_rows.push_back('{mk(OP_SET_TRANS,   15, 8'hFF,  7, 0), 1'b0, ws(0, 0, 0)});
		dir_rows.push_back('{mk(OP_BEGIN_WORD,  15, 8'h33,  9, 1), 1'b0, ws(0, 0, 0)});
		dir_rows.push_back('{mk(OP_FEED_LETTER,  0, 8'hFF,  0, 0), 1'b0, ws(0, 0, 0)});
		dir_rows.push_back('{mk(OP_SET_TRANS,    7, 8'hA5,  7, 0), 1'b0, ws(0, 0, 0)});
		dir_rows.push_back('{mk(OP_FEED_LETTER,  0, 8'hA5,  0, 0), 1'b0, ws(0, 0, 0)});
		dir_rows.push_back('{mk(OP_SET_ACCEPT,   7, 8'h00,  0, 1), 1'b0, ws(0, 0, 0)});
		dir_rows.push_back('{mk(OP_FEED_LETTER,  0, 8'hA5,  0, 0), 1'b0, ws(0, 0, 0)});
		dir_rows.push_back('{mk(OP_FEED_LETTER,  0, 8'h5A,  0, 0), 1'b0, ws(0, 0, 0)});
		dir_rows.push_back('{mk(OP_SET_TRANS,    7, 8'h5A,  8, 0), 1'b0, ws(0, 0, 0)});
		dir_rows.push_back('{mk(OP_FEED_LETTER,  0, 8'h5A,  0, 0), 1'b0, ws(0, 0, 0)});
		dir_rows.push_back('{mk(OP_BEGIN_WORD,   7, 8'h5A, 15, 1), 1'b0, ws(0, 0, 0)});
		dir_rows.push_back('{mk(OP_FEED_LETTER, 15, 8'h5A, 15, 1), 1'b0, ws(0, 0, 0)});
		dir_rows.push_back('{mk(OP_SET_ACCEPT,   0, 8'hFF, 15, 0), 1'b0, ws(0, 0, 0)});
		foreach (dir_rows[i])
			offer(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

		// random: mostly letters drawn from a small per-phase alphabet so words run deep
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
				default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			foreach (pool[k])
				pool[k] = 8'($urandom_range(255));
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				if (phase == 0 && n == 100)
					hold_armed = 1'b1;
				it = mk(OP_FEED_LETTER, $urandom_range(15), $urandom_range(255),
					$urandom_range(15), 1'($urandom_range(1)));
				if ($urandom_range(99) < 85)
					it.letter = pool[$urandom_range(7)];
				r = $urandom_range(99);
				if (r < 12)
					it.operation = OP_SET_TRANS;
				else if (r < 18)
					it.operation = OP_SET_ACCEPT;
				else if (r < 28)
					it.operation = OP_BEGIN_WORD;
				offer(it, 1'b0, ws(0, 0, 0));
			end
		end
		s_axis_tvalid <= 1'b0;

		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Covered %0d items (%0d directed), %0d words, %0d letters taken, %0d killed",
			items_sent, dir_rows.size(), words_begun, letters_taken, words_killed);
		$display("%0d results checked, %0d accepting, across idle, stall and hold-off phases",
			results_checked, accepted_seen);
		if (errors == 0 && pending_status.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* dfa_word_acceptor.f */
hw/rtl/dwa_pkg.sv
hw/rtl/dwa_table_ram.sv
hw/rtl/dwa_clear_seq.sv
hw/rtl/dfa_word_acceptor.sv
dv/dfa_word_acceptor_test.sv
